FILE: rtl/bda_pkg.sv
package bda_pkg;

   localparam int PINS = 8;
   localparam int TIME_W = 32;
   localparam int DELAY_W = 16;
   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE_DELAY = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_INITIAL = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_INTERVAL = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_PORT0_ENABLE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_ENABLE = 3'd4;

   localparam logic [DELAY_W-1:0] DEBOUNCE_DELAY_RESET = 16'd50;
   localparam logic [DELAY_W-1:0] REPEAT_INITIAL_RESET = 16'd500;
   localparam logic [DELAY_W-1:0] REPEAT_INTERVAL_RESET = 16'd100;
   localparam logic [PINS-1:0] PORT0_ENABLE_RESET = 8'hFF;
   localparam logic [PINS-1:0] REPEAT_ENABLE_RESET = 8'h00;
   localparam logic [PINS-1:0] IDLE_LEVELS = 8'hFF;

   typedef struct packed {
      logic [PINS-1:0] port0_pins;
      logic [PINS-1:0] port1_pins;
      logic [TIME_W-1:0] now_ms;
   } bda_req_type;

   typedef struct packed {
      logic [PINS-1:0] press0_pulses;
      logic [PINS-1:0] press1_pulses;
      logic [PINS-1:0] repeat_pulses;
      logic [PINS-1:0] stable0_levels;
      logic [PINS-1:0] stable1_levels;
   } bda_rsp_type;

   typedef struct packed {
      logic [DELAY_W-1:0] debounce_delay_ms;
      logic [DELAY_W-1:0] repeat_initial_delay_ms;
      logic [DELAY_W-1:0] repeat_interval_ms;
   } bda_timing_type;

   typedef struct packed {
      logic press;
      logic rose;
      logic stable;
   } bda_deb_status_type;

endpackage

FILE: rtl/button_debounce_autorepeat_top.sv
// Debounces two active-low 8-pin button ports from time-stamped samples and
// gives press pulses, auto-repeat pulses on held port 1 pins, and the
// debounced levels. One sample is taken per clock cycle unless the output
// stalls; its result is registered and shown in the next cycle. Each pin
// has its own lane that updates its state in the cycle of the transfer,
// and a single output register holds the merged result until it is taken.
// Configuration writes are taken at once and belong in idle periods.
module button_debounce_autorepeat_top
   import bda_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  bda_req_type req_payload,
   output logic rsp_valid,
   input  logic rsp_ready,
   output bda_rsp_type rsp_payload,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [DELAY_W-1:0] csr_data
);

   bda_timing_type timing_ff, timing_in;
   logic [PINS-1:0] port0_enable_ff, port0_enable_in;
   logic [PINS-1:0] repeat_enable_ff, repeat_enable_in;
   logic advance;
   bda_deb_status_type [PINS-1:0] deb0;
   bda_deb_status_type [PINS-1:0] deb1;
   logic [PINS-1:0] repeats;

   assign csr_ready = 1'b1;

   always_comb begin
      timing_in = timing_ff;
      port0_enable_in = port0_enable_ff;
      repeat_enable_in = repeat_enable_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_DEBOUNCE_DELAY: timing_in.debounce_delay_ms = csr_data;
            CSR_REPEAT_INITIAL: timing_in.repeat_initial_delay_ms = csr_data;
            CSR_REPEAT_INTERVAL: timing_in.repeat_interval_ms = csr_data;
            CSR_PORT0_ENABLE: port0_enable_in = csr_data[PINS-1:0];
            CSR_REPEAT_ENABLE: repeat_enable_in = csr_data[PINS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timing_ff.debounce_delay_ms <= DEBOUNCE_DELAY_RESET;
         timing_ff.repeat_initial_delay_ms <= REPEAT_INITIAL_RESET;
         timing_ff.repeat_interval_ms <= REPEAT_INTERVAL_RESET;
         port0_enable_ff <= PORT0_ENABLE_RESET;
         repeat_enable_ff <= REPEAT_ENABLE_RESET;
      end else begin
         timing_ff <= timing_in;
         port0_enable_ff <= port0_enable_in;
         repeat_enable_ff <= repeat_enable_in;
      end
   end

   for (genvar i = 0; i < PINS; i++) begin : g_lane
      bda_deb_lane u_deb0 (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .enable     (port0_enable_ff[i]),
         .raw        (req_payload.port0_pins[i]),
         .now_ms     (req_payload.now_ms),
         .delay_ms   (timing_ff.debounce_delay_ms),
         .idle_level (IDLE_LEVELS[i]),
         .status     (deb0[i])
      );

      bda_deb_lane u_deb1 (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .enable     (1'b1),
         .raw        (req_payload.port1_pins[i]),
         .now_ms     (req_payload.now_ms),
         .delay_ms   (timing_ff.debounce_delay_ms),
         .idle_level (IDLE_LEVELS[i]),
         .status     (deb1[i])
      );

      bda_rep_lane u_rep (
         .clock         (clock),
         .reset         (reset),
         .advance       (advance),
         .raw           (req_payload.port1_pins[i]),
         .repeat_enable (repeat_enable_ff[i]),
         .deb           (deb1[i]),
         .now_ms        (req_payload.now_ms),
         .timing        (timing_ff),
         .repeat_pulse  (repeats[i])
      );
   end

   bda_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .advance     (advance),
      .deb0        (deb0),
      .deb1        (deb1),
      .repeats     (repeats),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: rtl/bda_deb_lane.sv
module bda_deb_lane
   import bda_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic enable,
   input  logic raw,
   input  logic [TIME_W-1:0] now_ms,
   input  logic [DELAY_W-1:0] delay_ms,
   input  logic idle_level,
   output bda_deb_status_type status
);

   logic raw_prev_ff, raw_prev_in;
   logic stable_ff, stable_in;
   logic [TIME_W-1:0] change_time_ff, change_time_in;
   logic [TIME_W-1:0] elapsed;
   logic raw_change;
   logic settle;

   assign raw_change = raw != raw_prev_ff;
   assign elapsed = now_ms - change_time_ff;
   assign settle = enable && !raw_change && (elapsed > {{(TIME_W-DELAY_W){1'b0}}, delay_ms})
                   && (raw != stable_ff);

   always_comb begin
      raw_prev_in = raw_prev_ff;
      stable_in = stable_ff;
      change_time_in = change_time_ff;
      if (advance && enable) begin
         raw_prev_in = raw;
         if (raw_change) begin
            change_time_in = now_ms;
         end
         if (settle) begin
            stable_in = raw;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         raw_prev_ff <= idle_level;
         stable_ff <= idle_level;
         change_time_ff <= '0;
      end else begin
         raw_prev_ff <= raw_prev_in;
         stable_ff <= stable_in;
         change_time_ff <= change_time_in;
      end
   end

   assign status.press = settle && !raw;
   assign status.rose = settle && raw;
   assign status.stable = stable_in;

endmodule

FILE: rtl/bda_rep_lane.sv
module bda_rep_lane
   import bda_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic raw,
   input  logic repeat_enable,
   input  bda_deb_status_type deb,
   input  logic [TIME_W-1:0] now_ms,
   input  bda_timing_type timing,
   output logic repeat_pulse
);

   logic held_ff, held_in;
   logic [TIME_W-1:0] hold_start_ff, hold_start_in;
   logic [TIME_W-1:0] last_repeat_ff, last_repeat_in;
   logic [TIME_W-1:0] held_for;
   logic [TIME_W-1:0] since_repeat;
   logic start;

   assign start = deb.press && repeat_enable;
   assign held_for = now_ms - hold_start_ff;
   assign since_repeat = now_ms - last_repeat_ff;

   assign repeat_pulse = !raw && held_ff && repeat_enable && !start
      && (held_for > {{(TIME_W-DELAY_W){1'b0}}, timing.repeat_initial_delay_ms})
      && (since_repeat > {{(TIME_W-DELAY_W){1'b0}}, timing.repeat_interval_ms});

   always_comb begin
      held_in = held_ff;
      hold_start_in = hold_start_ff;
      last_repeat_in = last_repeat_ff;
      if (advance) begin
         if (start) begin
            held_in = 1'b1;
            hold_start_in = now_ms;
            last_repeat_in = now_ms;
         end else if (deb.rose) begin
            held_in = 1'b0;
         end
         if (repeat_pulse) begin
            last_repeat_in = now_ms;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 1'b0;
         hold_start_ff <= '0;
         last_repeat_ff <= '0;
      end else begin
         held_ff <= held_in;
         hold_start_ff <= hold_start_in;
         last_repeat_ff <= last_repeat_in;
      end
   end

endmodule

FILE: rtl/bda_merge.sv
module bda_merge
   import bda_pkg::*;
(
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic advance,
   input  bda_deb_status_type [PINS-1:0] deb0,
   input  bda_deb_status_type [PINS-1:0] deb1,
   input  logic [PINS-1:0] repeats,
   output logic rsp_valid,
   input  logic rsp_ready,
   output bda_rsp_type rsp_payload
);

   logic rsp_valid_ff, rsp_valid_in;
   bda_rsp_type rsp_ff, rsp_in;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign advance = req_valid && req_ready;

   always_comb begin
      for (int i = 0; i < PINS; i++) begin
         rsp_in.press0_pulses[i] = deb0[i].press;
         rsp_in.press1_pulses[i] = deb1[i].press;
         rsp_in.stable0_levels[i] = deb0[i].stable;
         rsp_in.stable1_levels[i] = deb1[i].stable;
      end
      rsp_in.repeat_pulses = repeats;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
